/* rtl/si_pkg.sv */
// Shared widths, pipeline payload type and divider step for segment_intersection.
// Used by the channel interfaces and the top level; depends on nothing.
package si_pkg;

  localparam int COORD_W   = 32;                 // Q16.16 coordinate
  localparam int DELTA_W   = COORD_W + 1;        // difference of two coordinates
  localparam int PROD_W    = 2 * DELTA_W;        // product of two deltas
  localparam int WIDE_W    = PROD_W + 1;         // det and numerators, signed
  localparam int MAG_W     = PROD_W;             // magnitude of det and sn
  localparam int HALF_W    = MAG_W / 2;          // sn is split in two halves
  localparam int PART_W    = HALF_W + COORD_W;   // one partial product
  localparam int DIV_STEPS = COORD_W;            // quotient bits, one per stage
  localparam int NUM_W     = MAG_W + DIV_STEPS;  // dividend sn * |delta|

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // One item inside the divider: remainders and quotient/dividend shift words
  typedef struct packed {
    logic               hit;
    logic               sx;
    logic               sy;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [MAG_W-1:0]   det;
    logic [MAG_W-1:0]   rx;
    logic [MAG_W-1:0]   ry;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
  } div_t;

  // One restoring division step for both quotients
  function automatic div_t div_step(input div_t d);
    logic [MAG_W:0] det2;
    logic [MAG_W:0] rx2;
    logic [MAG_W:0] ry2;
    logic [MAG_W:0] dfx;
    logic [MAG_W:0] dfy;
    logic           gex;
    logic           gey;
    div_t           o;
    o    = d;
    det2 = {1'b0, d.det};
    rx2  = {d.rx, d.qx[DIV_STEPS-1]};
    ry2  = {d.ry, d.qy[DIV_STEPS-1]};
    dfx  = rx2 - det2;
    dfy  = ry2 - det2;
    gex  = (rx2 >= det2);
    gey  = (ry2 >= det2);
    o.rx = gex ? dfx[MAG_W-1:0] : rx2[MAG_W-1:0];
    o.ry = gey ? dfy[MAG_W-1:0] : ry2[MAG_W-1:0];
    o.qx = {d.qx[DIV_STEPS-2:0], gex};
    o.qy = {d.qy[DIV_STEPS-2:0], gey};
    return o;
  endfunction

endpackage

/* rtl/si_in_if.sv */
// Input channel of segment_intersection: valid/ready plus two segments.
// Depends on si_pkg for the coordinate width.
interface si_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [si_pkg::COORD_W-1:0]   a_start_x;
  logic signed [si_pkg::COORD_W-1:0]   a_start_y;
  logic signed [si_pkg::COORD_W-1:0]   a_end_x;
  logic signed [si_pkg::COORD_W-1:0]   a_end_y;
  logic signed [si_pkg::COORD_W-1:0]   b_start_x;
  logic signed [si_pkg::COORD_W-1:0]   b_start_y;
  logic signed [si_pkg::COORD_W-1:0]   b_end_x;
  logic signed [si_pkg::COORD_W-1:0]   b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

/* rtl/si_out_if.sv */
// Result channel of segment_intersection: valid/ready, crossing flag and point.
// Depends on si_pkg for the coordinate width.
interface si_out_if;
  logic                                valid;
  logic                                ready;
  logic                                crosses;
  logic signed [si_pkg::COORD_W-1:0]   cross_x;
  logic signed [si_pkg::COORD_W-1:0]   cross_y;

  modport source (output valid, crosses, cross_x, cross_y, input ready);
  modport sink   (input  valid, crosses, cross_x, cross_y, output ready);
endinterface

/* rtl/segment_intersection.sv */
// Pipelined segment crossing test with Q16.16 crossing point.
// Depends on si_pkg, si_in_if and si_out_if.
//
// Usage:
//   items   : one transfer carries segment A (start, end) and segment B (start,
//             end), signed Q16.16. Each transfer yields exactly one result.
//   results : crosses plus the crossing point nudged +1 LSB in x and -1 LSB in
//             y (saturating); both coordinates read zero when crosses is 0.
//   Rate    : one item per cycle while the skid entry is empty. The depth is set by the
//             32-stage restoring divider, one quotient bit per stage, that
//             runs both coordinates in parallel behind five stages of deltas,
//             products, determinant, normalization and partial products.
//   Stall   : the last stage feeds an output register plus one skid entry.
//             The pipeline keeps moving while a result waits, and holds as a
//             whole only once the skid entry is filled; nothing is dropped.
//   Reset   : rst (synchronous) clears all valid bits; payload is not reset.
module segment_intersection (
  input logic clk,
  input logic rst,
  si_in_if.sink     items,
  si_out_if.source  results
);

  localparam int CW = si_pkg::COORD_W;
  localparam int DW = si_pkg::DELTA_W;
  localparam int PW = si_pkg::PROD_W;
  localparam int WW = si_pkg::WIDE_W;
  localparam int MW = si_pkg::MAG_W;
  localparam int HW = si_pkg::HALF_W;
  localparam int RW = si_pkg::PART_W;
  localparam int NW = si_pkg::NUM_W;
  localparam int NS = si_pkg::DIV_STEPS;

  logic adv;

  // stage 1: deltas
  logic                 s1_v;
  logic signed [DW-1:0] s1_dax, s1_day, s1_ex, s1_ey, s1_bx, s1_by;
  logic        [CW-1:0] s1_x1, s1_y1;

  // stage 2: products
  logic                 s2_v;
  logic signed [PW-1:0] s2_p0, s2_p1, s2_p2, s2_p3, s2_p4, s2_p5;
  logic signed [DW-1:0] s2_dax, s2_day;
  logic        [CW-1:0] s2_x1, s2_y1;

  // stage 3: determinant and numerators
  logic                 s3_v;
  logic signed [WW-1:0] s3_det, s3_sn, s3_tn;
  logic signed [DW-1:0] s3_dax, s3_day;
  logic        [CW-1:0] s3_x1, s3_y1;
  logic        [DW-1:0] s3_dax_abs, s3_day_abs;
  logic                 s3_neg;

  // stage 4: sign normalized
  logic                 s4_v;
  logic        [WW-1:0] s4_det, s4_sn, s4_tn;
  logic                 s4_nz;
  logic                 s4_sx, s4_sy;
  logic        [CW-1:0] s4_mx, s4_my;
  logic        [CW-1:0] s4_x1, s4_y1;

  // stage 5: crossing flag and partial products of the dividends
  logic                 s5_v;
  logic                 s5_hit;
  logic        [MW-1:0] s5_det;
  logic        [RW-1:0] s5_pxl, s5_pxh, s5_pyl, s5_pyh;
  logic                 s5_sx, s5_sy;
  logic        [CW-1:0] s5_x1, s5_y1;
  logic        [NW-1:0] num_x, num_y;

  // divider stages
  si_pkg::div_t         dv [0:NS];
  logic        [NS:0]   dvv;

  // stage 7: point along A
  logic                 s7_v;
  logic                 s7_hit;
  logic        [CW-1:0] s7_px, s7_py;

  // output register and skid entry
  logic                 ov, sv;
  logic                 oc, sc;
  logic        [CW-1:0] ox, oy, skx, sky;
  logic        [CW-1:0] fin_x, fin_y;
  logic                 push;

  // the whole pipeline advances unless the skid entry is occupied
  assign adv         = !sv;
  assign items.ready = adv;
  assign push        = adv && s7_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      dvv  <= '0;
      s7_v <= 1'b0;
    end else if (adv) begin
      s1_v <= items.valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      dvv  <= {dvv[NS-1:0], s5_v};
      s7_v <= dvv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dax <= {items.a_end_x[CW-1], items.a_end_x} - {items.a_start_x[CW-1], items.a_start_x};
      s1_day <= {items.a_end_y[CW-1], items.a_end_y} - {items.a_start_y[CW-1], items.a_start_y};
      s1_ex  <= {items.b_start_x[CW-1], items.b_start_x} - {items.b_end_x[CW-1], items.b_end_x};
      s1_ey  <= {items.b_start_y[CW-1], items.b_start_y} - {items.b_end_y[CW-1], items.b_end_y};
      s1_bx  <= {items.b_start_x[CW-1], items.b_start_x} - {items.a_start_x[CW-1], items.a_start_x};
      s1_by  <= {items.b_start_y[CW-1], items.b_start_y} - {items.a_start_y[CW-1], items.a_start_y};
      s1_x1  <= items.a_start_x;
      s1_y1  <= items.a_start_y;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p0  <= s1_dax * s1_ey;
      s2_p1  <= s1_day * s1_ex;
      s2_p2  <= s1_ey * s1_bx;
      s2_p3  <= s1_ex * s1_by;
      s2_p4  <= s1_dax * s1_by;
      s2_p5  <= s1_day * s1_bx;
      s2_dax <= s1_dax;
      s2_day <= s1_day;
      s2_x1  <= s1_x1;
      s2_y1  <= s1_y1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_det <= {s2_p0[PW-1], s2_p0} - {s2_p1[PW-1], s2_p1};
      s3_sn  <= {s2_p2[PW-1], s2_p2} - {s2_p3[PW-1], s2_p3};
      s3_tn  <= {s2_p4[PW-1], s2_p4} - {s2_p5[PW-1], s2_p5};
      s3_dax <= s2_dax;
      s3_day <= s2_day;
      s3_x1  <= s2_x1;
      s3_y1  <= s2_y1;
    end
  end

  assign s3_neg     = s3_det[WW-1];
  assign s3_dax_abs = s3_dax[DW-1] ? DW'(-s3_dax) : s3_dax;
  assign s3_day_abs = s3_day[DW-1] ? DW'(-s3_day) : s3_day;

  // flip signs so that det is non-negative
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_det <= s3_neg ? WW'(-s3_det) : s3_det;
      s4_sn  <= s3_neg ? WW'(-s3_sn)  : s3_sn;
      s4_tn  <= s3_neg ? WW'(-s3_tn)  : s3_tn;
      s4_nz  <= |s3_det;
      s4_sx  <= s3_dax[DW-1];
      s4_sy  <= s3_day[DW-1];
      s4_mx  <= s3_dax_abs[CW-1:0];
      s4_my  <= s3_day_abs[CW-1:0];
      s4_x1  <= s3_x1;
      s4_y1  <= s3_y1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hit <= s4_nz && !s4_sn[WW-1] && (|s4_sn) && (s4_sn[MW-1:0] < s4_det[MW-1:0])
                && !s4_tn[WW-1] && (s4_tn[MW-1:0] <= s4_det[MW-1:0]);
      s5_det <= s4_det[MW-1:0];
      s5_pxl <= s4_sn[HW-1:0] * s4_mx;
      s5_pxh <= s4_sn[MW-1:HW] * s4_mx;
      s5_pyl <= s4_sn[HW-1:0] * s4_my;
      s5_pyh <= s4_sn[MW-1:HW] * s4_my;
      s5_sx  <= s4_sx;
      s5_sy  <= s4_sy;
      s5_x1  <= s4_x1;
      s5_y1  <= s4_y1;
    end
  end

  assign num_x = {{HW{1'b0}}, s5_pxl} + {s5_pxh, {HW{1'b0}}};
  assign num_y = {{HW{1'b0}}, s5_pyl} + {s5_pyh, {HW{1'b0}}};

  // quotient fits in CW bits, so the top of the dividend is already below det
  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].hit <= s5_hit;
      dv[0].sx  <= s5_sx;
      dv[0].sy  <= s5_sy;
      dv[0].x1  <= s5_x1;
      dv[0].y1  <= s5_y1;
      dv[0].det <= s5_det;
      dv[0].rx  <= num_x[NW-1:NS];
      dv[0].ry  <= num_y[NW-1:NS];
      dv[0].qx  <= num_x[NS-1:0];
      dv[0].qy  <= num_y[NS-1:0];
    end
  end

  for (genvar gi = 0; gi < NS; gi++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[gi+1] <= si_pkg::div_step(dv[gi]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_hit <= dv[NS].hit;
      s7_px  <= dv[NS].sx ? dv[NS].x1 - dv[NS].qx : dv[NS].x1 + dv[NS].qx;
      s7_py  <= dv[NS].sy ? dv[NS].y1 - dv[NS].qy : dv[NS].y1 + dv[NS].qy;
    end
  end

  // nudge with saturation, zero when there is no crossing
  always_comb begin
    fin_x = '0;
    fin_y = '0;
    if (s7_hit) begin
      fin_x = (s7_px == si_pkg::COORD_MAX) ? s7_px : s7_px + 1'b1;
      fin_y = (s7_py == si_pkg::COORD_MIN) ? s7_py : s7_py - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || results.ready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || results.ready) begin
      if (sv) begin
        oc <= sc;
        ox <= skx;
        oy <= sky;
      end else begin
        oc <= s7_hit;
        ox <= fin_x;
        oy <= fin_y;
      end
    end else if (push) begin
      sc  <= s7_hit;
      skx <= fin_x;
      sky <= fin_y;
    end
  end

  assign results.valid   = ov;
  assign results.crosses = oc;
  assign results.cross_x = ox;
  assign results.cross_y = oy;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !results.ready))
    else $error("skid entry filled without a stalled output");

  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.crosses) |-> (results.cross_x == '0 && results.cross_y == '0))
    else $error("nonzero point reported without a crossing");

endmodule
